// File: hdl/saicl_pkg.sv
`default_nettype none
package saicl_pkg;

	// Cache geometry
	localparam int WAY_KB     = 4;
	localparam int LINE_WORDS = 4;
	localparam int MAX_WAYS   = 4;

	localparam int WAY_LOG  = $clog2(WAY_KB * 1024);
	localparam int LINE_LOG = $clog2(LINE_WORDS);
	localparam int TAG_W    = 32 - WAY_LOG;
	localparam int WIDX_W   = WAY_LOG - 2;
	localparam int LINE_W   = WIDX_W - LINE_LOG;
	localparam int ROWS     = 2 ** LINE_W;
	localparam int MASK_W   = 2 ** LINE_LOG;
	localparam int WAY_W    = 2;
	localparam int WADDR_W  = WAY_W + WIDX_W;
	localparam int CFG_W    = 3;
	localparam int DATA_W   = 32;

	// Result kinds
	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_ALLOC = 2'd2
	} outcome_t;

	// One line index across all ways: tags and per-word valid masks
	typedef struct packed {
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tags;
		logic [MAX_WAYS-1:0][MASK_W-1:0] masks;
	} row_t;

	// Requests from the sequencer to the storage
	typedef struct packed {
		logic               row_re;
		logic [LINE_W-1:0]  row_raddr;
		logic               row_we;
		logic [LINE_W-1:0]  row_waddr;
		row_t               row_wdata;
		logic               word_re;
		logic [WADDR_W-1:0] word_raddr;
		logic               word_we;
		logic [WADDR_W-1:0] word_waddr;
		logic [DATA_W-1:0]  word_wdata;
	} mem_req_t;

endpackage
`default_nettype wire

// File: hdl/saicl_store.sv
`default_nettype none
module saicl_store
	import saicl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mem_req_t          req,
	output row_t                   row_rdata,
	output logic [DATA_W-1:0]      word_rdata
);

	row_t              row_mem [ROWS];
	logic [DATA_W-1:0] word_mem [2 ** WADDR_W];
	row_t              row_rd_q;
	logic [ROWS-1:0]   row_ok_q;
	logic              rd_ok_q;

	// Tag and mask rows: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.row_we) begin
			row_mem[req.row_waddr] <= req.row_wdata;
		end
		if (req.row_re) begin
			row_rd_q <= row_mem[req.row_raddr];
		end
	end

	// Track rows written since reset; an unwritten row reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (req.row_we) begin
				row_ok_q[req.row_waddr] <= 1'b1;
			end
			if (req.row_re) begin
				rd_ok_q <= row_ok_q[req.row_raddr];
			end
		end
	end

	assign row_rdata = rd_ok_q ? row_rd_q : '0;

	// Instruction words
	always_ff @(posedge clk) begin
		if (req.word_we) begin
			word_mem[req.word_waddr] <= req.word_wdata;
		end
		if (req.word_re) begin
			word_rdata <= word_mem[req.word_raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/set_assoc_insn_cache_lookup_unit.sv
`default_nettype none
// Set-associative instruction cache lookup, 4 KB per way, 4-word lines, up to four
// ways (cfg_wdata sets how many are searched; 0 counts as one, above four as four).
// Each fetch runs these steps from acceptance to its word on the output: the row
// of tags and valid masks is read at the accepting edge, then one shared tag
// comparator checks one way per cycle from way 0 until a match or the last way in
// use, a valid hit then reads the word memory, and a final step loads the output
// register (held off while the previous word still waits there). The next fetch is
// taken only after that load, once the sequencer is back in its idle state.
// in_ready is high only between fetches; a finished word may wait in the output
// register while the next fetch is taken. Tag misses fill the first way whose line is
// wholly invalid, otherwise the round-robin way. Storage is clean right after reset.
module set_assoc_insn_cache_lookup_unit
	import saicl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DATA_W-1:0] address,
	input  wire logic [DATA_W-1:0] fill_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      word,
	output logic [1:0]             outcome,
	output logic [WAY_W-1:0]       way
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WREAD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   ways_cfg_q;
	logic [WAY_W-1:0]   ways_m1_q;
	logic [WAY_W-1:0]   ptr_q;
	logic [WAY_W-1:0]   scan_q;
	logic               empty_seen_q;
	logic [WAY_W-1:0]   empty_way_q;
	logic [TAG_W-1:0]   tag_q;
	logic [LINE_W-1:0]  line_q;
	logic [WIDX_W-1:0]  widx_q;
	logic [DATA_W-1:0]  fill_q;
	logic [DATA_W-1:0]  res_word_q;
	outcome_t           res_kind_q;
	logic [WAY_W-1:0]   res_way_q;

	mem_req_t           req;
	row_t               row;
	logic [DATA_W-1:0]  word_rdata;

	logic               accept;
	logic               out_free;
	logic [WAY_W-1:0]   ways_m1;
	logic [TAG_W-1:0]   cur_tag;
	logic [MASK_W-1:0]  cur_mask;
	logic [MASK_W-1:0]  bit_mask;
	logic               tag_hit;
	logic               word_ok;
	logic               last_way;
	logic               have_empty;
	logic [WAY_W-1:0]   empty_way;
	logic [WAY_W-1:0]   rr_way;
	logic [WAY_W-1:0]   rr_next;
	logic [WAY_W-1:0]   victim;

	saicl_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.row_rdata  (row),
		.word_rdata (word_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// Clamp the way count to one through MAX_WAYS, kept as count minus one
	always_comb begin
		if (ways_cfg_q == '0) begin
			ways_m1 = '0;
		end else if (ways_cfg_q > CFG_W'(MAX_WAYS)) begin
			ways_m1 = WAY_W'(MAX_WAYS - 1);
		end else begin
			ways_m1 = WAY_W'(ways_cfg_q - CFG_W'(1));
		end
	end

	// Shared comparator on the way under scan
	assign cur_tag  = row.tags[scan_q];
	assign cur_mask = row.masks[scan_q];
	assign bit_mask = MASK_W'(1) << widx_q[LINE_LOG-1:0];
	assign tag_hit  = (cur_tag == tag_q);
	assign word_ok  = |(cur_mask & bit_mask);
	assign last_way = (scan_q == ways_m1_q);

	// Victim choice: first wholly invalid way, else round robin
	assign have_empty = empty_seen_q || (cur_mask == '0);
	assign empty_way  = empty_seen_q ? empty_way_q : scan_q;
	assign rr_way     = (ptr_q > ways_m1_q) ? '0 : ptr_q;
	assign rr_next    = (rr_way == ways_m1_q) ? '0 : rr_way + WAY_W'(1);
	assign victim     = have_empty ? empty_way : rr_way;

	// Storage requests
	always_comb begin
		req            = '0;
		req.row_raddr  = address[WAY_LOG-1:2+LINE_LOG];
		req.row_re     = accept;
		req.row_waddr  = line_q;
		req.row_wdata  = row;
		req.word_raddr = {scan_q, widx_q};
		req.word_wdata = fill_q;
		req.word_waddr = {scan_q, widx_q};
		if (state_q == ST_SCAN) begin
			if (tag_hit) begin
				if (word_ok) begin
					req.word_re = 1'b1;
				end else begin
					req.word_we                = 1'b1;
					req.row_we                 = 1'b1;
					req.row_wdata.masks[scan_q] = cur_mask | bit_mask;
				end
			end else if (last_way) begin
				req.word_we                 = 1'b1;
				req.word_waddr              = {victim, widx_q};
				req.row_we                  = 1'b1;
				req.row_wdata.tags[victim]  = tag_q;
				req.row_wdata.masks[victim] = bit_mask;
			end
		end
	end

	// Sequencer, configuration, pointer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ways_cfg_q   <= CFG_W'(MAX_WAYS);
			ways_m1_q    <= '0;
			ptr_q        <= '0;
			scan_q       <= '0;
			empty_seen_q <= 1'b0;
			empty_way_q  <= '0;
			tag_q        <= '0;
			line_q       <= '0;
			widx_q       <= '0;
			fill_q       <= '0;
			res_word_q   <= '0;
			res_kind_q   <= OUT_HIT;
			res_way_q    <= '0;
			out_valid    <= 1'b0;
			word         <= '0;
			outcome      <= '0;
			way          <= '0;
		end else begin
			if (cfg_we) begin
				ways_cfg_q <= cfg_wdata;
			end
			// drop the output word once taken, unless a new one replaces it
			if (out_valid && out_ready && state_q != ST_EMIT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tag_q        <= address[DATA_W-1:WAY_LOG];
						line_q       <= address[WAY_LOG-1:2+LINE_LOG];
						widx_q       <= address[WAY_LOG-1:2];
						fill_q       <= fill_word;
						ways_m1_q    <= ways_m1;
						scan_q       <= '0;
						empty_seen_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tag_hit) begin
						res_way_q <= scan_q;
						if (word_ok) begin
							res_kind_q <= OUT_HIT;
							state_q    <= ST_WREAD;
						end else begin
							res_kind_q <= OUT_FILL;
							res_word_q <= fill_q;
							state_q    <= ST_EMIT;
						end
					end else if (last_way) begin
						res_way_q  <= victim;
						res_kind_q <= OUT_ALLOC;
						res_word_q <= fill_q;
						if (!have_empty) begin
							ptr_q <= rr_next;
						end
						state_q <= ST_EMIT;
					end else begin
						// advance to the next way, remember the first empty line
						if (!empty_seen_q && cur_mask == '0) begin
							empty_seen_q <= 1'b1;
							empty_way_q  <= scan_q;
						end
						scan_q <= scan_q + WAY_W'(1);
					end
				end
				ST_WREAD: begin
					res_word_q <= word_rdata;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						word      <= res_word_q;
						outcome   <= res_kind_q;
						way       <= res_way_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
